>>> rtl/core/oas_pkg.sv
// Shared types, constants and helpers for the obstacle avoidance sequencer.
// No dependencies; every other file of the block but oas_chan_if imports this package.
package oas_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned DIST_W  = 9;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned BND_W   = 20;

  localparam logic [CMD_W-1:0] CMD_KEEP  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FWD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REV   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd5;

  localparam logic [IDX_W-1:0] REG_NEAR_THRESHOLD = 3'd0;
  localparam logic [IDX_W-1:0] REG_DRIVE_SPEED    = 3'd1;
  localparam logic [IDX_W-1:0] REG_TURN_SPEED     = 3'd2;
  localparam logic [IDX_W-1:0] REG_REVERSE_MS     = 3'd3;
  localparam logic [IDX_W-1:0] REG_TURN_MS        = 3'd4;
  localparam logic [IDX_W-1:0] REG_PAUSE_MS       = 3'd5;

  localparam logic [DIST_W-1:0]  RST_NEAR_THRESHOLD = 9'd20;
  localparam logic [SPEED_W-1:0] RST_DRIVE_SPEED    = 8'd150;
  localparam logic [SPEED_W-1:0] RST_TURN_SPEED     = 8'd200;
  localparam logic [DUR_W-1:0]   RST_REVERSE_MS     = 16'd600;
  localparam logic [DUR_W-1:0]   RST_TURN_MS        = 16'd600;
  localparam logic [DUR_W-1:0]   RST_PAUSE_MS       = 16'd1000;

  typedef struct packed {
    logic [NOW_W-1:0]  now_ms;
    logic [DIST_W-1:0] range_cm;
  } in_item_t;

  typedef struct packed {
    logic [CMD_W-1:0]   motor_cmd;
    logic [SPEED_W-1:0] motor_speed;
    logic               searching;
    logic [DIST_W-1:0]  front_cm;
    logic [DIST_W-1:0]  left_cm;
    logic [DIST_W-1:0]  right_cm;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] reg_index;
    logic [DUR_W-1:0] wr_data;
  } cfg_wr_t;

  typedef struct packed {
    logic [DIST_W-1:0]  near_threshold_cm;
    logic [SPEED_W-1:0] drive_speed;
    logic [SPEED_W-1:0] turn_speed;
  } cfg_t;

  // Phase end points measured from the start of a search.
  typedef struct packed {
    logic [BND_W-1:0] rev_end;
    logic [BND_W-1:0] left_end;
    logic [BND_W-1:0] lpause_end;
    logic [BND_W-1:0] right_end;
    logic [BND_W-1:0] rpause_end;
    logic [BND_W-1:0] back_end;
    logic [BND_W-1:0] last_end;
  } bnd_t;

  function automatic bnd_t bounds_f(logic [DUR_W-1:0] rev_ms, logic [DUR_W-1:0] turn_ms,
                                    logic [DUR_W-1:0] pause_ms);
    logic [BND_W-1:0] r_w;
    logic [BND_W-1:0] t_w;
    logic [BND_W-1:0] p_w;
    bnd_t             b;
    r_w = BND_W'(rev_ms);
    t_w = BND_W'(turn_ms);
    p_w = BND_W'(pause_ms);
    b.rev_end    = r_w;
    b.left_end   = r_w + t_w;
    b.lpause_end = b.left_end + p_w;
    b.right_end  = b.lpause_end + (t_w << 1);
    b.rpause_end = b.right_end + p_w;
    b.back_end   = b.rpause_end + (t_w << 1);
    b.last_end   = b.back_end + t_w;
    return b;
  endfunction

endpackage

>>> rtl/core/oas_chan_if.sv
// Valid/ready channel carrying one payload per transfer.
// Depends on nothing; the payload type is set where the channel is instantiated.
interface oas_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

>>> rtl/core/oas_cfg_regs.sv
// Configuration registers and the precomputed search phase end points.
// Depends on oas_pkg and the oas_chan_if write channel.
module oas_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  oas_chan_if.sink      cfg_i,
  output oas_pkg::cfg_t cfg_o,
  output oas_pkg::bnd_t bnd_o
);
  import oas_pkg::*;

  cfg_t             cfg_q;
  logic [DUR_W-1:0] rev_ms_q;
  logic [DUR_W-1:0] turn_ms_q;
  logic [DUR_W-1:0] pause_ms_q;
  bnd_t             bnd_q;
  bnd_t             bnd_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_threshold_cm <= RST_NEAR_THRESHOLD;
      cfg_q.drive_speed       <= RST_DRIVE_SPEED;
      cfg_q.turn_speed        <= RST_TURN_SPEED;
      rev_ms_q                <= RST_REVERSE_MS;
      turn_ms_q               <= RST_TURN_MS;
      pause_ms_q              <= RST_PAUSE_MS;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        REG_NEAR_THRESHOLD: cfg_q.near_threshold_cm <= cfg_i.data.wr_data[DIST_W-1:0];
        REG_DRIVE_SPEED:    cfg_q.drive_speed <= cfg_i.data.wr_data[SPEED_W-1:0];
        REG_TURN_SPEED:     cfg_q.turn_speed <= cfg_i.data.wr_data[SPEED_W-1:0];
        REG_REVERSE_MS:     rev_ms_q <= cfg_i.data.wr_data;
        REG_TURN_MS:        turn_ms_q <= cfg_i.data.wr_data;
        REG_PAUSE_MS:       pause_ms_q <= cfg_i.data.wr_data;
        default: ;
      endcase
    end
  end

  assign bnd_d = bounds_f(rev_ms_q, turn_ms_q, pause_ms_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_q <= bounds_f(RST_REVERSE_MS, RST_TURN_MS, RST_PAUSE_MS);
    end else begin
      bnd_q <= bnd_d;
    end
  end

  assign cfg_o = cfg_q;
  assign bnd_o = bnd_q;

endmodule

>>> rtl/core/oas_seq_core.sv
// Sequencer state and the combinational phase decode that yields one command.
// Depends on oas_pkg; driven by the registered input item of the top level.
module oas_seq_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  oas_pkg::in_item_t  item_i,
  input  oas_pkg::cfg_t      cfg_i,
  input  oas_pkg::bnd_t      bnd_i,
  output oas_pkg::out_item_t result_o
);
  import oas_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > BND_W) ? TIME_BITS : BND_W;

  logic                 mode_q, mode_d;
  logic                 begun_q, begun_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [DIST_W-1:0]    front_q, front_d;
  logic [DIST_W-1:0]    left_q, left_d;
  logic [DIST_W-1:0]    right_q, right_d;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic [CMP_W-1:0]     e;
  logic [CMD_W-1:0]     cmd;
  logic [SPEED_W-1:0]   speed;
  logic                 end_search;

  assign now_t   = item_i.now_ms[TIME_BITS-1:0];
  assign elapsed = begun_q ? (now_t - start_q) : '0;
  assign e       = CMP_W'(elapsed);

  always_comb begin
    mode_d     = mode_q;
    begun_d    = begun_q;
    start_d    = start_q;
    front_d    = front_q;
    left_d     = left_q;
    right_d    = right_q;
    cmd        = CMD_KEEP;
    end_search = 1'b0;
    if (!mode_q) begin
      cmd     = CMD_FWD;
      front_d = item_i.range_cm;
      if (item_i.range_cm < cfg_i.near_threshold_cm) begin
        mode_d = 1'b1;
      end
    end else begin
      if (!begun_q) begin
        begun_d = 1'b1;
        start_d = now_t;
        cmd     = CMD_REV;
      end
      if (e >= CMP_W'(bnd_i.rev_end) && e < CMP_W'(bnd_i.left_end)) begin
        cmd = CMD_LEFT;
      end else if (e >= CMP_W'(bnd_i.left_end) && e < CMP_W'(bnd_i.lpause_end)) begin
        cmd = CMD_STOP;
        if (left_q == '0) begin
          left_d = item_i.range_cm;
        end
      end else if (e >= CMP_W'(bnd_i.lpause_end) && e < CMP_W'(bnd_i.right_end)) begin
        cmd = CMD_RIGHT;
      end else if (e >= CMP_W'(bnd_i.right_end) && e < CMP_W'(bnd_i.rpause_end)) begin
        cmd = CMD_STOP;
        if (right_q == '0) begin
          right_d = item_i.range_cm;
        end
      end else if (e >= CMP_W'(bnd_i.rpause_end) && e <= CMP_W'(bnd_i.last_end)) begin
        if (left_q < right_q) begin
          end_search = 1'b1;
        end else if (e < CMP_W'(bnd_i.back_end)) begin
          cmd = CMD_LEFT;
        end else begin
          end_search = 1'b1;
        end
      end
      if (end_search) begin
        left_d  = '0;
        right_d = '0;
        mode_d  = 1'b0;
        begun_d = 1'b0;
        start_d = '0;
      end
    end
  end

  always_comb begin
    case (cmd) inside
      CMD_FWD, CMD_REV:    speed = cfg_i.drive_speed;
      CMD_LEFT, CMD_RIGHT: speed = cfg_i.turn_speed;
      default:             speed = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      begun_q <= 1'b0;
      start_q <= '0;
      front_q <= '0;
      left_q  <= '0;
      right_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      begun_q <= begun_d;
      start_q <= start_d;
      front_q <= front_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign result_o.motor_cmd   = cmd;
  assign result_o.motor_speed = speed;
  assign result_o.searching   = mode_d;
  assign result_o.front_cm    = front_d;
  assign result_o.left_cm     = left_d;
  assign result_o.right_cm    = right_d;

endmodule

>>> rtl/core/obstacle_avoid_sequencer.sv
// Obstacle avoidance sequencer: one motor command per time stamp and distance reading.
// One item is accepted per clock as long as the result side takes every transfer. Each item is held in the
// input register and decoded by the combinational phase compare logic, and its result is captured in the
// output register once that register is empty or being read; until then the item waits in the input register.
// Configuration writes update the configuration registers, which feed the registered phase end
// points, and must only be made while no item is in flight.
module obstacle_avoid_sequencer #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  oas_chan_if.sink   cfg_i,
  oas_chan_if.sink   in_i,
  oas_chan_if.source out_o
);
  import oas_pkg::*;

  cfg_t      cfg;
  bnd_t      bnd;
  out_item_t result;

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_data_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;
  logic      step;
  logic      in_take;

  oas_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg),
    .bnd_o  (bnd)
  );

  oas_seq_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (s1_data_q),
    .cfg_i    (cfg),
    .bnd_i    (bnd),
    .result_o (result)
  );

  assign step       = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || !out_valid_q || out_o.ready;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_i.data;
    end
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

`ifndef SYNTHESIS
  a_cruise_sides_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.searching |-> out_data_q.left_cm == '0 &&
                                              out_data_q.right_cm == '0)
    else $error("side readings kept outside a search");

  a_reverse_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.motor_cmd == CMD_REV |-> out_data_q.searching)
    else $error("reverse command given while cruising");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result produced without a registered input item");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for obstacle_avoid_sequencer: a predictor class tracks the search
// state and configuration and checks every motor command transfer in order.
// Depends on oas_pkg, oas_chan_if and obstacle_avoid_sequencer from the RTL.
module testbench;
  import oas_pkg::*;

  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 88;
  localparam int unsigned CYCLE_LIMIT = 400000;

  class steer_predictor;
    logic [DIST_W-1:0]  thr_cm;
    logic [SPEED_W-1:0] drive_spd;
    logic [SPEED_W-1:0] turn_spd;
    logic [DUR_W-1:0]   rev_len;
    logic [DUR_W-1:0]   turn_len;
    logic [DUR_W-1:0]   pause_len;
    logic               search_mode;
    logic               search_begun;
    logic [NOW_W-1:0]   start_time;
    logic [DIST_W-1:0]  front_store;
    logic [DIST_W-1:0]  left_store;
    logic [DIST_W-1:0]  right_store;
    logic [NOW_W-1:0]   tmask;
    out_item_t          cmds_due[$];
    int unsigned        errors;
    int unsigned        n_results;

    function new();
      thr_cm       = RST_NEAR_THRESHOLD;
      drive_spd    = RST_DRIVE_SPEED;
      turn_spd     = RST_TURN_SPEED;
      rev_len      = RST_REVERSE_MS;
      turn_len     = RST_TURN_MS;
      pause_len    = RST_PAUSE_MS;
      search_mode  = 1'b0;
      search_begun = 1'b0;
      start_time   = '0;
      front_store  = '0;
      left_store   = '0;
      right_store  = '0;
      tmask        = NOW_W'((64'd1 << TIME_BITS) - 64'd1);
      errors       = 0;
      n_results    = 0;
    endfunction

    function int unsigned pending();
      return cmds_due.size();
    endfunction

    function void set_reg(cfg_wr_t w);
      case (w.reg_index)
        REG_NEAR_THRESHOLD: thr_cm    = w.wr_data[DIST_W-1:0];
        REG_DRIVE_SPEED:    drive_spd = w.wr_data[SPEED_W-1:0];
        REG_TURN_SPEED:     turn_spd  = w.wr_data[SPEED_W-1:0];
        REG_REVERSE_MS:     rev_len   = w.wr_data;
        REG_TURN_MS:        turn_len  = w.wr_data;
        REG_PAUSE_MS:       pause_len = w.wr_data;
        default: ;
      endcase
    endfunction

    function void end_search();
      left_store   = '0;
      right_store  = '0;
      search_mode  = 1'b0;
      search_begun = 1'b0;
      start_time   = '0;
    endfunction

    task note_step(in_item_t it);
      logic [NOW_W-1:0]  now;
      logic [NOW_W-1:0]  diff;
      logic [DIST_W-1:0] rng;
      logic [CMD_W-1:0]  cmd;
      longint unsigned   r;
      longint unsigned   t;
      longint unsigned   p;
      longint unsigned   e;
      out_item_t         o;
      now = it.now_ms & tmask;
      rng = it.range_cm;
      cmd = CMD_KEEP;
      if (!search_mode) begin
        cmd = CMD_FWD;
        front_store = rng;
        if (rng < thr_cm) search_mode = 1'b1;
      end else begin
        r = rev_len;
        t = turn_len;
        p = pause_len;
        if (!search_begun) begin
          search_begun = 1'b1;
          start_time = now;
          cmd = CMD_REV;
        end
        diff = (now - start_time) & tmask;
        e = diff;
        if (e >= r && e < r + t) begin
          cmd = CMD_LEFT;
        end else if (e >= r + t && e < r + t + p) begin
          cmd = CMD_STOP;
          if (left_store == 0) left_store = rng;
        end else if (e >= r + t + p && e < r + 3 * t + p) begin
          cmd = CMD_RIGHT;
        end else if (e >= r + 3 * t + p && e < r + 3 * t + 2 * p) begin
          cmd = CMD_STOP;
          if (right_store == 0) right_store = rng;
        end else if (e >= r + 3 * t + 2 * p && e <= r + 6 * t + 2 * p) begin
          if (left_store < right_store) end_search();
          else if (e < r + 5 * t + 2 * p) cmd = CMD_LEFT;
          else end_search();
        end
      end
      o.motor_cmd = cmd;
      if (cmd == CMD_FWD || cmd == CMD_REV) o.motor_speed = drive_spd;
      else if (cmd == CMD_LEFT || cmd == CMD_RIGHT) o.motor_speed = turn_spd;
      else o.motor_speed = '0;
      o.searching = search_mode;
      o.front_cm  = front_store;
      o.left_cm   = left_store;
      o.right_cm  = right_store;
      cmds_due.push_back(o);
    endtask

    task report(string msg);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0d, expected %0d", n_results, name, got, want));
    endtask

    task check_cmd(out_item_t got);
      out_item_t want;
      n_results++;
      if (cmds_due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing due", n_results));
      end else begin
        want = cmds_due.pop_front();
        compare_field("motor_cmd", 32'(got.motor_cmd), 32'(want.motor_cmd));
        compare_field("motor_speed", 32'(got.motor_speed), 32'(want.motor_speed));
        compare_field("searching", 32'(got.searching), 32'(want.searching));
        compare_field("front_cm", 32'(got.front_cm), 32'(want.front_cm));
        compare_field("left_cm", 32'(got.left_cm), 32'(want.left_cm));
        compare_field("right_cm", 32'(got.right_cm), 32'(want.right_cm));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned src_idle = 28;
  int unsigned sink_idle = 47;
  int unsigned cycles = 0;
  logic [DIST_W-1:0] cur_thr;
  longint unsigned cur_span;
  steer_predictor sb = new();

  oas_chan_if #(.payload_t(cfg_wr_t))   cfg_if ();
  oas_chan_if #(.payload_t(in_item_t))  in_if ();
  oas_chan_if #(.payload_t(out_item_t)) out_if ();

  obstacle_avoid_sequencer #(
    .TIME_BITS(TIME_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** obstacle_avoid_sequencer: FAILED **");
      $finish;
    end
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.data);
      if (in_if.valid && in_if.ready) sb.note_step(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_cmd(out_if.data);
    end
  end

  function automatic in_item_t mk(logic [NOW_W-1:0] now, logic [DIST_W-1:0] rng);
    in_item_t it;
    it.now_ms   = now;
    it.range_cm = rng;
    return it;
  endfunction

  function automatic logic [DIST_W-1:0] pick_range();
    case ($urandom_range(19))
      0, 1, 2, 3: return (cur_thr > 0) ? DIST_W'($urandom_range(cur_thr - 1, 0)) : '0;
      4:          return '0;
      5:          return DIST_W'($urandom_range(511, 501));
      default:    return DIST_W'($urandom_range(500, 0));
    endcase
  endfunction

  // Entered and left at a falling edge; valid stays high when items follow back to back.
  task automatic send_step(input in_item_t it);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < src_idle) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic quiesce(input int extra);
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() > 0);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    cfg_wr_t w;
    w.reg_index = idx;
    w.wr_data   = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [DIST_W-1:0] thr, input logic [SPEED_W-1:0] ds,
                           input logic [SPEED_W-1:0] ts, input logic [DUR_W-1:0] r,
                           input logic [DUR_W-1:0] t, input logic [DUR_W-1:0] p);
    quiesce(4);
    cfg_write(REG_NEAR_THRESHOLD, DUR_W'(thr));
    cfg_write(REG_DRIVE_SPEED, DUR_W'(ds));
    cfg_write(REG_TURN_SPEED, DUR_W'(ts));
    cfg_write(REG_REVERSE_MS, r);
    cfg_write(REG_TURN_MS, t);
    cfg_write(REG_PAUSE_MS, p);
    repeat (3) @(negedge clk_i);
    cur_thr  = thr;
    cur_span = longint'(r) + 6 * longint'(t) + 2 * longint'(p);
  endtask

  function automatic logic [SPEED_W-1:0] pick_speed();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return SPEED_W'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] pick_dur();
    case ($urandom_range(9))
      0:       return DUR_W'($urandom_range(2000, 1));
      1:       return 16'd1;
      default: return DUR_W'($urandom_range(30, 1));
    endcase
  endfunction

  initial begin
    logic [NOW_W-1:0] base;
    logic [NOW_W-1:0] now;
    int unsigned      sel;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cur_thr  = RST_NEAR_THRESHOLD;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset configuration: a full search across the time stamp wrap, ending with a left turn.
    base = 32'hFFFF_FFF0;
    send_step(mk(32'd0, 9'd500));
    send_step(mk(32'hFFFF_FFFF, 9'd20));
    send_step(mk(32'd100, 9'd511));
    send_step(mk(32'd200, 9'd19));
    send_step(mk(base, 9'd0));
    send_step(mk(base + 599, 9'd300));
    send_step(mk(base + 600, 9'd7));
    send_step(mk(base + 1199, 9'd7));
    send_step(mk(base + 1200, 9'd0));
    send_step(mk(base + 1500, 9'd300));
    send_step(mk(base + 2199, 9'd100));
    send_step(mk(base + 2200, 9'd100));
    send_step(mk(base + 3399, 9'd100));
    send_step(mk(base + 3400, 9'd0));
    send_step(mk(base + 3500, 9'd300));
    send_step(mk(base + 4400, 9'd9));
    send_step(mk(base + 5599, 9'd9));
    send_step(mk(base + 6201, 9'd9));
    send_step(mk(base + 5600, 9'd9));
    // A second search where the left side is nearer, so it ends at once.
    send_step(mk(32'd1000, 9'd0));
    send_step(mk(32'd5000, 9'd100));
    send_step(mk(32'd6200, 9'd1));
    send_step(mk(32'd8400, 9'd2));
    send_step(mk(32'd9400, 9'd50));
    send_step(mk(32'd9500, 9'd20));

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph >= 8) begin
        src_idle  = 0;
        sink_idle = 0;
      end else if (ph >= 4) begin
        src_idle  = 47;
        sink_idle = 28;
      end
      case (ph)
        0:       configure(9'd500, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1:       configure(9'd0, 8'd0, 8'd0, 16'd1, 16'd1, 16'd1);
        2:       configure(9'd1, pick_speed(), pick_speed(), 16'd1, 16'd1, 16'd1);
        7:       configure(9'd500, pick_speed(), pick_speed(), 16'hFFFF, pick_dur(), 16'd1);
        default: configure(DIST_W'($urandom_range(500, 1)), pick_speed(), pick_speed(),
                           pick_dur(), pick_dur(), pick_dur());
      endcase
      if ($urandom_range(3) == 0) now = 32'hFFFF_FFFF - NOW_W'(cur_span / 2);
      else now = $urandom();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) quiesce(0);
        sel = $urandom_range(39);
        if (sel == 0) begin
          send_step(mk($urandom(), pick_range()));
        end else begin
          if (sel == 1) now = now - NOW_W'($urandom_range(int'(cur_span), 1));
          else now = now + NOW_W'($urandom_range(int'(cur_span / 6) + 1, 0));
          send_step(mk(now, pick_range()));
        end
      end
    end

    quiesce(8);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** obstacle_avoid_sequencer: PASSED **");
    end else begin
      $display("** obstacle_avoid_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
